// File: hdl/qivr_pkg.sv
// Shared types and constants for the quaternion inverse vector rotation pipeline.
package qivr_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ProdWidth = 32;
  localparam int unsigned EntryWidth = 34;
  localparam int unsigned TermWidth = EntryWidth + DataWidth;
  localparam int unsigned SumWidth = TermWidth + 2;
  localparam int unsigned FracBits = 28;
  localparam int unsigned QuotWidth = SumWidth - FracBits;

  localparam logic signed [EntryWidth-1:0] OneQ28 = EntryWidth'(64'sd1 <<< FracBits);
  localparam logic signed [SumWidth-1:0] HalfQ28 = SumWidth'(64'sd1 <<< (FracBits - 1));

  typedef struct packed {
    logic signed [DataWidth-1:0] w;
    logic signed [DataWidth-1:0] x;
    logic signed [DataWidth-1:0] y;
    logic signed [DataWidth-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] x;
    logic signed [DataWidth-1:0] y;
    logic signed [DataWidth-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [ProdWidth-1:0] xx;
    logic signed [ProdWidth-1:0] yy;
    logic signed [ProdWidth-1:0] zz;
    logic signed [ProdWidth-1:0] xy;
    logic signed [ProdWidth-1:0] xz;
    logic signed [ProdWidth-1:0] yz;
    logic signed [ProdWidth-1:0] wx;
    logic signed [ProdWidth-1:0] wy;
    logic signed [ProdWidth-1:0] wz;
  } prod_t;

  typedef struct packed {
    logic signed [EntryWidth-1:0] m00;
    logic signed [EntryWidth-1:0] m01;
    logic signed [EntryWidth-1:0] m02;
    logic signed [EntryWidth-1:0] m10;
    logic signed [EntryWidth-1:0] m11;
    logic signed [EntryWidth-1:0] m12;
    logic signed [EntryWidth-1:0] m20;
    logic signed [EntryWidth-1:0] m21;
    logic signed [EntryWidth-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [TermWidth-1:0] t00;
    logic signed [TermWidth-1:0] t01;
    logic signed [TermWidth-1:0] t02;
    logic signed [TermWidth-1:0] t10;
    logic signed [TermWidth-1:0] t11;
    logic signed [TermWidth-1:0] t12;
    logic signed [TermWidth-1:0] t20;
    logic signed [TermWidth-1:0] t21;
    logic signed [TermWidth-1:0] t22;
  } term_t;

endpackage

// File: hdl/qivr_products.sv
// Stage one: the nine pairwise products of the quaternion components.
module qivr_products
  import qivr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  quat_t quat,
  input  vec3_t vec,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t prod,
  output vec3_t vec_q
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod.xx <= quat.x * quat.x;
      prod.yy <= quat.y * quat.y;
      prod.zz <= quat.z * quat.z;
      prod.xy <= quat.x * quat.y;
      prod.xz <= quat.x * quat.z;
      prod.yz <= quat.y * quat.z;
      prod.wx <= quat.w * quat.x;
      prod.wy <= quat.w * quat.y;
      prod.wz <= quat.w * quat.z;
      vec_q   <= vec;
    end
  end

endmodule

// File: hdl/qivr_matrix.sv
// Stage two: the transposed rotation matrix entries in Q.28.
module qivr_matrix
  import qivr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t prod,
  input  vec3_t vec,
  output logic  out_valid,
  input  logic  out_ready,
  output mat_t  mat,
  output vec3_t vec_q
);

  logic signed [EntryWidth-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  assign xx = EntryWidth'(prod.xx);
  assign yy = EntryWidth'(prod.yy);
  assign zz = EntryWidth'(prod.zz);
  assign xy = EntryWidth'(prod.xy);
  assign xz = EntryWidth'(prod.xz);
  assign yz = EntryWidth'(prod.yz);
  assign wx = EntryWidth'(prod.wx);
  assign wy = EntryWidth'(prod.wy);
  assign wz = EntryWidth'(prod.wz);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mat.m00 <= OneQ28 - ((yy + zz) <<< 1);
      mat.m01 <= (xy + wz) <<< 1;
      mat.m02 <= (xz - wy) <<< 1;
      mat.m10 <= (xy - wz) <<< 1;
      mat.m11 <= OneQ28 - ((xx + zz) <<< 1);
      mat.m12 <= (yz + wx) <<< 1;
      mat.m20 <= (xz + wy) <<< 1;
      mat.m21 <= (yz - wx) <<< 1;
      mat.m22 <= OneQ28 - ((xx + yy) <<< 1);
      vec_q   <= vec;
    end
  end

endmodule

// File: hdl/qivr_terms.sv
// Stage three: each matrix entry times its vector component.
module qivr_terms
  import qivr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  mat_t  mat,
  input  vec3_t vec,
  output logic  out_valid,
  input  logic  out_ready,
  output term_t term
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      term.t00 <= mat.m00 * vec.x;
      term.t01 <= mat.m01 * vec.y;
      term.t02 <= mat.m02 * vec.z;
      term.t10 <= mat.m10 * vec.x;
      term.t11 <= mat.m11 * vec.y;
      term.t12 <= mat.m12 * vec.z;
      term.t20 <= mat.m20 * vec.x;
      term.t21 <= mat.m21 * vec.y;
      term.t22 <= mat.m22 * vec.z;
    end
  end

endmodule

// File: hdl/qivr_round.sv
// Stage four: row sums, rounding to integer and saturation to 16 bits.
module qivr_round
  import qivr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  term_t term,
  output logic  out_valid,
  input  logic  out_ready,
  output vec3_t rot
);

  function automatic logic signed [DataWidth-1:0] round_sat(
    input logic signed [TermWidth-1:0] a,
    input logic signed [TermWidth-1:0] b,
    input logic signed [TermWidth-1:0] c
  );
    logic signed [SumWidth-1:0]  sum;
    logic signed [QuotWidth-1:0] quot;
    logic                        over;
    sum  = SumWidth'(a) + SumWidth'(b) + SumWidth'(c) + HalfQ28;
    quot = QuotWidth'(sum >>> FracBits);
    over = (quot[QuotWidth-1:DataWidth-1] != {(QuotWidth - DataWidth + 1){1'b0}}) &&
           (quot[QuotWidth-1:DataWidth-1] != {(QuotWidth - DataWidth + 1){1'b1}});
    if (!over) begin
      return quot[DataWidth-1:0];
    end else if (quot[QuotWidth-1]) begin
      return {1'b1, {(DataWidth - 1){1'b0}}};
    end else begin
      return {1'b0, {(DataWidth - 1){1'b1}}};
    end
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rot.x <= round_sat(term.t00, term.t01, term.t02);
      rot.y <= round_sat(term.t10, term.t11, term.t12);
      rot.z <= round_sat(term.t20, term.t21, term.t22);
    end
  end

endmodule

// File: hdl/quaternion_inverse_vector_rotate_core.sv
// Top level of the quaternion inverse vector rotation pipeline.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
//   output   out_valid / out_ready rot_x, rot_y, rot_z
//
// One request is taken every cycle unless out_ready stalls a full pipeline; results leave in order.
// The four stages are quaternion products, matrix entries, entry-by-vector
// products, and row sum with rounding and saturation.
// Reset clears the valid bit of every stage; the data registers are not reset.
// A stall holds each full stage in place; empty stages ahead of it keep filling.
module quaternion_inverse_vector_rotate_core
  import qivr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DataWidth-1:0] quat_w,
  input  logic signed [DataWidth-1:0] quat_x,
  input  logic signed [DataWidth-1:0] quat_y,
  input  logic signed [DataWidth-1:0] quat_z,
  input  logic signed [DataWidth-1:0] vec_x,
  input  logic signed [DataWidth-1:0] vec_y,
  input  logic signed [DataWidth-1:0] vec_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DataWidth-1:0] rot_x,
  output logic signed [DataWidth-1:0] rot_y,
  output logic signed [DataWidth-1:0] rot_z
);

  quat_t quat;
  vec3_t vec;
  prod_t prod;
  vec3_t vec1;
  mat_t  mat;
  vec3_t vec2;
  term_t term;
  vec3_t rot;
  logic  valid1, ready1;
  logic  valid2, ready2;
  logic  valid3, ready3;

  assign quat = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
  assign vec  = '{x: vec_x, y: vec_y, z: vec_z};

  qivr_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .quat      (quat),
    .vec       (vec),
    .out_valid (valid1),
    .out_ready (ready1),
    .prod      (prod),
    .vec_q     (vec1)
  );

  qivr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid1),
    .in_ready  (ready1),
    .prod      (prod),
    .vec       (vec1),
    .out_valid (valid2),
    .out_ready (ready2),
    .mat       (mat),
    .vec_q     (vec2)
  );

  qivr_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid2),
    .in_ready  (ready2),
    .mat       (mat),
    .vec       (vec2),
    .out_valid (valid3),
    .out_ready (ready3),
    .term      (term)
  );

  qivr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid3),
    .in_ready  (ready3),
    .term      (term),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot       (rot)
  );

  assign rot_x = rot.x;
  assign rot_y = rot.y;
  assign rot_z = rot.z;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the quaternion inverse vector rotation core: directed table plus random requests.
module tb_top
  import qivr_pkg::*;
();

  typedef logic signed [DataWidth-1:0] code_t;

  typedef struct packed {
    quat_t q;
    vec3_t v;
    logic  typed;
    vec3_t rot;
  } table_row_t;

  localparam int RowSlots = 32;
  localparam int PendSlots = 2048;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  code_t quat_w, quat_x, quat_y, quat_z;
  code_t vec_x, vec_y, vec_z;
  logic  out_valid;
  logic  out_ready;
  code_t rot_x, rot_y, rot_z;

  logic  req_typed;
  vec3_t req_typed_rot;

  vec3_t       pending_rot[PendSlots];
  logic [10:0] pend_wr = '0;
  logic [10:0] pend_rd = '0;
  table_row_t  directed_rows[RowSlots];
  int          row_count = 0;
  int          fail_count = 0;
  bit          sender_idles = 1'b1;

  quaternion_inverse_vector_rotate_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic code_t round_saturate(longint sum);
    longint q;
    q = (sum + (longint'(1) << (FracBits - 1))) >>> FracBits;
    if (q > 32767) begin
      return 16'sh7fff;
    end
    if (q < -32768) begin
      return 16'sh8000;
    end
    return code_t'(q);
  endfunction

  function automatic vec3_t inverse_rotate(quat_t q, vec3_t v);
    longint w, x, y, z, vx, vy, vz, one;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    vec3_t r;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    one = longint'(1) << FracBits;
    m00 = one - 2 * (y * y + z * z);
    m01 = 2 * (x * y + w * z);
    m02 = 2 * (x * z - w * y);
    m10 = 2 * (x * y - w * z);
    m11 = one - 2 * (x * x + z * z);
    m12 = 2 * (y * z + w * x);
    m20 = 2 * (x * z + w * y);
    m21 = 2 * (y * z - w * x);
    m22 = one - 2 * (x * x + y * y);
    r.x = round_saturate(m00 * vx + m01 * vy + m02 * vz);
    r.y = round_saturate(m10 * vx + m11 * vy + m12 * vz);
    r.z = round_saturate(m20 * vx + m21 * vy + m22 * vz);
    return r;
  endfunction

  function automatic code_t corner_code();
    case ($urandom_range(6))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd16384;
      3: return 16'sd16384;
      4: return -16'sd1;
      5: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (!sender_idles || roll < 50) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(quat_t q, vec3_t v, logic typed, vec3_t rot);
    table_row_t row;
    row.q = q;
    row.v = v;
    row.typed = typed;
    row.rot = rot;
    directed_rows[5'(row_count)] = row;
    row_count++;
  endtask

  task automatic send_request(quat_t q, vec3_t v, logic typed, vec3_t rot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= q.w;
    quat_x <= q.x;
    quat_y <= q.y;
    quat_z <= q.z;
    vec_x <= v.x;
    vec_y <= v.y;
    vec_z <= v.z;
    req_typed <= typed;
    req_typed_rot <= rot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    vec3_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (req_typed) begin
          pending_rot[pend_wr] = req_typed_rot;
        end else begin
          pending_rot[pend_wr] = inverse_rotate({quat_w, quat_x, quat_y, quat_z},
                                                {vec_x, vec_y, vec_z});
        end
        pend_wr = pend_wr + 11'd1;
      end
      if (out_valid && out_ready) begin
        if (pend_wr == pend_rd) begin
          $error("Result (%0d, %0d, %0d) arrived with no request outstanding.",
                 rot_x, rot_y, rot_z);
          fail_count++;
        end else begin
          want = pending_rot[pend_rd];
          pend_rd = pend_rd + 11'd1;
          if (rot_x !== want.x) begin
            $error("rot_x: expected %0d, got %0d", want.x, rot_x);
            fail_count++;
          end
          if (rot_y !== want.y) begin
            $error("rot_y: expected %0d, got %0d", want.y, rot_y);
            fail_count++;
          end
          if (rot_z !== want.z) begin
            $error("rot_z: expected %0d, got %0d", want.z, rot_z);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int  hold_left;
    logic level;
    out_ready = 1'b0;
    hold_left = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0) begin
        level = !level;
        if (level) begin
          hold_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
        end else begin
          hold_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        out_ready <= level;
      end else begin
        hold_left--;
      end
    end
  end

  initial begin
    int    i, n, mix, guard;
    int    ia, ib, ic, id;
    real   ra, rb, rc, rd, norm;
    quat_t q;
    vec3_t v;
    vec3_t unused_rot;
    table_row_t row;

    rst = 1'b1;
    in_valid = 1'b0;
    quat_w = '0;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    req_typed = 1'b0;
    req_typed_rot = '0;
    unused_rot = '0;

    add_row('{16384, 0, 0, 0}, '{1000, -2000, 3000}, 1'b1, '{1000, -2000, 3000});
    add_row('{16384, 0, 0, 0}, '{32767, -32768, 0}, 1'b1, '{32767, -32768, 0});
    add_row('{0, 0, 0, 0}, '{12345, -1, -32768}, 1'b1, '{12345, -1, -32768});
    add_row('{-16384, 0, 0, 0}, '{-32768, 32767, -1}, 1'b1, '{-32768, 32767, -1});
    add_row('{-32768, 0, 0, 0}, '{-7, 32767, 9}, 1'b1, '{-7, 32767, 9});
    add_row('{0, 16384, 0, 0}, '{5, -32768, 32767}, 1'b1, '{5, 32767, -32767});
    add_row('{0, 0, 16384, 0}, '{100, 200, 300}, 1'b1, '{-100, 200, -300});
    add_row('{0, 0, 0, 16384}, '{100, 200, 300}, 1'b1, '{-100, -200, 300});
    add_row('{0, -32768, 0, 0}, '{1, 2, -3}, 1'b1, '{1, -14, 21});
    add_row('{0, 8192, 0, 0}, '{7, 3, -3}, 1'b1, '{7, 2, -1});
    add_row('{0, 0, 8192, 0}, '{1, -1, 1}, 1'b1, '{1, -1, 1});
    add_row('{11585, 0, 0, 11585}, '{10000, 0, -10000}, 1'b0, unused_rot);
    add_row('{11585, 11585, 0, 0}, '{0, 10000, 20000}, 1'b0, unused_rot);
    add_row('{8192, 8192, 8192, 8192}, '{1000, 2000, 3000}, 1'b0, unused_rot);
    add_row('{8192, -8192, 8192, -8192}, '{-32768, 32767, -32768}, 1'b0, unused_rot);
    add_row('{-32768, -32768, -32768, -32768}, '{1, -1, 1}, 1'b0, unused_rot);
    add_row('{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767}, 1'b0, unused_rot);
    add_row('{32767, 32767, 32767, 32767}, '{-32768, -32768, -32768}, 1'b0, unused_rot);
    add_row('{32767, -32768, 32767, -32768}, '{32767, -32768, 32767}, 1'b0, unused_rot);
    add_row('{-1, -1, -1, -1}, '{-1, -1, -1}, 1'b0, unused_rot);
    add_row('{15137, 0, 6270, 0}, '{-32768, -32768, -32768}, 1'b0, unused_rot);
    add_row('{16383, 1, -1, 1}, '{32767, 32767, 32767}, 1'b0, unused_rot);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < row_count; n++) begin
      row = directed_rows[5'(n)];
      send_request(row.q, row.v, row.typed, row.rot);
    end

    for (i = 0; i < 1100; i++) begin
      if (i % 150 == 0) begin
        sender_idles = ($urandom_range(2) != 0);
      end
      mix = $urandom_range(99);
      if (mix < 60) begin
        ia = $urandom_range(20000) - 10000;
        ib = $urandom_range(20000) - 10000;
        ic = $urandom_range(20000) - 10000;
        id = $urandom_range(20000) - 10000;
        ra = ia;
        rb = ib;
        rc = ic;
        rd = id;
        norm = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
        if (norm < 1.0) begin
          q = '{16384, 0, 0, 0};
        end else begin
          q.w = code_t'($rtoi(ra / norm * 16384.0));
          q.x = code_t'($rtoi(rb / norm * 16384.0));
          q.y = code_t'($rtoi(rc / norm * 16384.0));
          q.z = code_t'($rtoi(rd / norm * 16384.0));
        end
      end else if (mix < 85) begin
        q.w = code_t'($urandom);
        q.x = code_t'($urandom);
        q.y = code_t'($urandom);
        q.z = code_t'($urandom);
      end else begin
        q.w = corner_code();
        q.x = corner_code();
        q.y = corner_code();
        q.z = corner_code();
      end
      mix = $urandom_range(99);
      if (mix < 70) begin
        v.x = code_t'($urandom);
        v.y = code_t'($urandom);
        v.z = code_t'($urandom);
      end else if (mix < 90) begin
        v.x = code_t'($urandom_range(4000) - 2000);
        v.y = code_t'($urandom_range(4000) - 2000);
        v.z = code_t'($urandom_range(4000) - 2000);
      end else begin
        v.x = corner_code();
        v.y = corner_code();
        v.z = corner_code();
      end
      send_request(q, v, 1'b0, unused_rot);
    end

    in_valid <= 1'b0;
    guard = 0;
    while (pend_wr != pend_rd && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pend_wr != pend_rd) begin
      $error("%0d expected results never arrived.", 11'(pend_wr - pend_rd));
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/qivr_pkg.sv
hdl/qivr_products.sv
hdl/qivr_matrix.sv
hdl/qivr_terms.sv
hdl/qivr_round.sv
hdl/quaternion_inverse_vector_rotate_core.sv
bench/tb_top.sv
